>>> rtl/core/p256_modular_multiplier_assert.svh
// Assertion macros for the P-256 modular multiplier checker.
// Depends on nothing; expects clk and rst_n in the including scope.
`ifndef P256_MODULAR_MULTIPLIER_ASSERT_SVH
`define P256_MODULAR_MULTIPLIER_ASSERT_SVH

// same-cycle implication
`define P256MM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("p256mm assertion failed");

// next-cycle implication
`define P256MM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("p256mm assertion failed");

`endif

>>> rtl/core/p256mm_pkg.sv
// Package for the P-256 modular multiplier: item types, prime words, reduction table.
// Depends on nothing.
package p256mm_pkg;

  localparam int WORDS  = 8;
  localparam int WORD_W = 32;
  localparam int IDX_W  = $clog2(WORDS);
  localparam int PROD_W = $clog2(2 * WORDS);
  localparam int ACC_W  = 38;
  localparam int TOP_W  = 4;

  typedef struct packed {
    logic [WORD_W-1:0] a_word;
    logic [WORD_W-1:0] b_word;
    logic              last_in;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] product_word;
    logic              last_out;
  } out_item_t;

  typedef enum logic [2:0] {
    COEF_ZERO,
    COEF_POS,
    COEF_DBL,
    COEF_TRI,
    COEF_NEG
  } coef_t;

  localparam logic [WORD_W-1:0] P_WORDS [WORDS] = '{
    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000001, 32'hFFFFFFFF
  };

  // reduction terms: eight slots for each result word, low word first
  localparam logic [PROD_W-1:0] RED_IDX [WORDS*WORDS] = '{
    4'd0, 4'd8,  4'd9,  4'd11, 4'd12, 4'd13, 4'd14, 4'd0,
    4'd1, 4'd9,  4'd10, 4'd12, 4'd13, 4'd14, 4'd15, 4'd0,
    4'd2, 4'd10, 4'd11, 4'd13, 4'd14, 4'd15, 4'd0,  4'd0,
    4'd3, 4'd11, 4'd12, 4'd13, 4'd15, 4'd8,  4'd9,  4'd0,
    4'd4, 4'd12, 4'd13, 4'd14, 4'd9,  4'd10, 4'd0,  4'd0,
    4'd5, 4'd13, 4'd14, 4'd15, 4'd10, 4'd11, 4'd0,  4'd0,
    4'd6, 4'd14, 4'd15, 4'd13, 4'd8,  4'd9,  4'd0,  4'd0,
    4'd7, 4'd15, 4'd8,  4'd10, 4'd11, 4'd12, 4'd13, 4'd0
  };

  localparam coef_t RED_COEF [WORDS*WORDS] = '{
    COEF_POS, COEF_POS, COEF_POS, COEF_NEG, COEF_NEG, COEF_NEG, COEF_NEG, COEF_ZERO,
    COEF_POS, COEF_POS, COEF_POS, COEF_NEG, COEF_NEG, COEF_NEG, COEF_NEG, COEF_ZERO,
    COEF_POS, COEF_POS, COEF_POS, COEF_NEG, COEF_NEG, COEF_NEG, COEF_ZERO, COEF_ZERO,
    COEF_POS, COEF_DBL, COEF_DBL, COEF_POS, COEF_NEG, COEF_NEG, COEF_NEG, COEF_ZERO,
    COEF_POS, COEF_DBL, COEF_DBL, COEF_POS, COEF_NEG, COEF_NEG, COEF_ZERO, COEF_ZERO,
    COEF_POS, COEF_DBL, COEF_DBL, COEF_POS, COEF_NEG, COEF_NEG, COEF_ZERO, COEF_ZERO,
    COEF_POS, COEF_TRI, COEF_DBL, COEF_POS, COEF_NEG, COEF_NEG, COEF_ZERO, COEF_ZERO,
    COEF_POS, COEF_TRI, COEF_POS, COEF_NEG, COEF_NEG, COEF_NEG, COEF_NEG, COEF_ZERO
  };

endpackage

>>> rtl/core/p256_modular_multiplier.sv
// P-256 modular multiplier top level: operand stores, shared 32x32 MAC, reduction, fix-up.
// Depends on p256mm_pkg.
//
//   channel  ports                      handshake
//   input    start, busy, in_item       taken when start && !busy
//   result   out_valid, out_item        one word per cycle, no back-pressure
//
// An item without last_in is stored and busy stays low. The item with last_in starts
// the work: word multiply-accumulate on one 32x32 multiplier, reduction on one
// accumulator, passes of the word-serial p add or subtract (1 to 6 passes), then
// the result words; busy is high throughout.
// Reset clears the sequencer and word count; the operand stores are not cleared.
module p256_modular_multiplier (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  p256mm_pkg::in_item_t  in_item,
  output logic                  out_valid,
  output p256mm_pkg::out_item_t out_item
);
  import p256mm_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_RED, ST_FIX, ST_EMIT} state_t;

  state_t                   state_r;
  logic [6:0]               cnt_r;
  logic [IDX_W-1:0]         wcnt_r;
  logic                     s2_vld_r;
  logic [IDX_W-1:0]         s2_i_r, s2_j_r;
  logic [2*WORD_W-1:0]      prod_r;
  logic [WORD_W-1:0]        carry_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [TOP_W-1:0]         top_r;
  logic                     sel_r;
  logic                     fix_cy_r;
  logic                     out_valid_r;
  out_item_t                out_item_r;

  logic [WORD_W-1:0] a_store_r [WORDS];
  logic [WORD_W-1:0] b_store_r [WORDS];
  logic [WORD_W-1:0] prod_store_r [2*WORDS];
  logic [WORD_W-1:0] bank_r [2][WORDS];

  logic                    accept;
  logic [PROD_W-1:0]       prod_addr;
  logic [WORD_W-1:0]       prod_rd;
  logic [2*WORD_W-1:0]     uv;
  logic signed [ACC_W-1:0] x_ext, term, acc_sum, acc_shift;
  logic [IDX_W-1:0]        fw;
  logic [WORD_W-1:0]       t_rd;
  logic                    fix_add;
  logic [WORD_W:0]         fix_sum;
  logic [TOP_W-1:0]        top_new;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    prod_addr = (state_r == ST_MUL) ? ({1'b0, s2_i_r} + {1'b0, s2_j_r})
                                    : RED_IDX[cnt_r[5:0]];
    prod_rd   = prod_store_r[prod_addr];
    uv = ((s2_i_r == '0) ? '0 : {{WORD_W{1'b0}}, prod_rd}) + prod_r
       + {{WORD_W{1'b0}}, ((s2_j_r == '0) ? '0 : carry_r)};
    x_ext = signed'({{(ACC_W-WORD_W){1'b0}}, prod_rd});
    case (RED_COEF[cnt_r[5:0]])
      COEF_POS: term = x_ext;
      COEF_DBL: term = x_ext <<< 1;
      COEF_TRI: term = x_ext + (x_ext <<< 1);
      COEF_NEG: term = -x_ext;
      default:  term = '0;
    endcase
    acc_sum   = acc_r + term;
    acc_shift = acc_sum >>> WORD_W;
    fw      = cnt_r[IDX_W-1:0];
    t_rd    = bank_r[sel_r][fw];
    fix_add = top_r[TOP_W-1];
    fix_sum = {1'b0, t_rd} + {1'b0, (fix_add ? P_WORDS[fw] : ~P_WORDS[fw])}
            + {{WORD_W{1'b0}}, fix_cy_r};
    top_new = top_r + (fix_add ? '0 : {TOP_W{1'b1}}) + {{(TOP_W-1){1'b0}}, fix_sum[WORD_W]};
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_store_r[wcnt_r] <= in_item.a_word;
      b_store_r[wcnt_r] <= in_item.b_word;
    end
    if (state_r == ST_MUL && s2_vld_r) begin
      prod_store_r[prod_addr] <= uv[WORD_W-1:0];
      if (s2_j_r == IDX_W'(WORDS-1)) begin
        prod_store_r[{1'b1, s2_i_r}] <= uv[2*WORD_W-1:WORD_W];
      end
    end
    if (state_r == ST_RED && cnt_r[IDX_W-1:0] == IDX_W'(WORDS-1)) begin
      bank_r[0][cnt_r[5:3]] <= acc_sum[WORD_W-1:0];
    end
    if (state_r == ST_FIX) begin
      bank_r[~sel_r][fw] <= fix_sum[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      wcnt_r      <= '0;
      s2_vld_r    <= 1'b0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_item.last_in) begin
              state_r <= ST_MUL;
              cnt_r   <= '0;
              wcnt_r  <= '0;
            end else begin
              wcnt_r <= wcnt_r + 1'b1;
            end
          end
        end
        ST_MUL: begin
          s2_vld_r <= !cnt_r[6];
          if (!cnt_r[6]) begin
            prod_r <= a_store_r[cnt_r[2:0]] * b_store_r[cnt_r[5:3]];
            s2_i_r <= cnt_r[5:3];
            s2_j_r <= cnt_r[2:0];
            cnt_r  <= cnt_r + 7'd1;
          end
          if (s2_vld_r) begin
            carry_r <= uv[2*WORD_W-1:WORD_W];
          end
          if (cnt_r[6] && !s2_vld_r) begin
            state_r <= ST_RED;
            cnt_r   <= '0;
            acc_r   <= '0;
          end
        end
        ST_RED: begin
          acc_r <= (cnt_r[2:0] == 3'd7) ? acc_shift : acc_sum;
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r[5:0] == 6'd63) begin
            state_r  <= ST_FIX;
            cnt_r    <= '0;
            top_r    <= acc_shift[TOP_W-1:0];
            sel_r    <= 1'b0;
            fix_cy_r <= !acc_shift[TOP_W-1];
          end
        end
        ST_FIX: begin
          fix_cy_r <= fix_sum[WORD_W];
          cnt_r    <= cnt_r + 7'd1;
          if (fw == IDX_W'(WORDS-1)) begin
            cnt_r <= '0;
            if (fix_add || !top_new[TOP_W-1]) begin
              sel_r    <= ~sel_r;
              top_r    <= top_new;
              fix_cy_r <= !top_new[TOP_W-1];
            end else begin
              state_r <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          out_valid_r             <= 1'b1;
          out_item_r.product_word <= bank_r[sel_r][cnt_r[IDX_W-1:0]];
          out_item_r.last_out     <= (cnt_r[IDX_W-1:0] == IDX_W'(WORDS-1));
          cnt_r                   <= cnt_r + 7'd1;
          if (cnt_r[IDX_W-1:0] == IDX_W'(WORDS-1)) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/p256mm_checker.sv
// Port-level checker for the P-256 modular multiplier, bound to the top level.
// Depends on p256mm_pkg and p256_modular_multiplier_assert.svh.
`include "p256_modular_multiplier_assert.svh"

module p256mm_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input p256mm_pkg::in_item_t  in_item,
  input logic                  out_valid,
  input p256mm_pkg::out_item_t out_item
);
  import p256mm_pkg::*;

  `P256MM_ASSERT_NOW(a_out_while_busy, out_valid, busy)
  `P256MM_ASSERT_NEXT(a_burst_contiguous, out_valid && !out_item.last_out, out_valid)
  `P256MM_ASSERT_NEXT(a_last_frees, out_valid && out_item.last_out, !busy && !out_valid)
  `P256MM_ASSERT_NEXT(a_plain_item_quiet, start && !busy && !in_item.last_in,
                      !busy && !out_valid)
  `P256MM_ASSERT_NEXT(a_last_item_busy, start && !busy && in_item.last_in, busy)

endmodule

bind p256_modular_multiplier p256mm_checker u_p256mm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
